// ----- rtl/rac_pkg.sv -----
// ----------------------------------------------------------------------------
// rac_pkg
// Types and constants shared by the continued-fraction approximation block.
// ----------------------------------------------------------------------------
package rac_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DEN_W   = 32;
  localparam int unsigned IN_W    = 64;
  localparam int unsigned OUT_W   = 104;

  localparam logic [DEN_W-1:0] MAX_DEN_RESET = 32'd1000000000;
  localparam logic [30:0]      TERM_LIMIT    = 31'h7FFFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_CHECK,
    ST_TERM,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/rational_approximation_contfrac.sv -----
// ----------------------------------------------------------------------------
// rational_approximation_contfrac
// Best rational approximation of a signed fixed-point value by continued
// fraction convergents, limited by a configurable maximum denominator.
//
// Channel  Dir  Content
// s_axis   in   tdata[63:0] real_value
// m_axis   out  tdata[63:0] numerator, [95:64] denominator, [96] exact
// cfg      in   cfg_wen / cfg_wdata[31:0] max_denominator
//
// Each term runs a bit-serial restoring division, then a shift-and-add multiply
// over the significant bits of the term, then the check and term states.
// A request runs over at most about 47 terms.
// The input is not ready while a request is in work; reset is synchronous and
// sets the limit to 1000000000.
// A finished result waits in the output register until it is taken.
// ----------------------------------------------------------------------------
module rational_approximation_contfrac
  import rac_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [63:0] real_value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [63:0] numerator, [95:64] denominator,
                                      // [96] exact
  input  logic             cfg_wen,
  input  logic [DEN_W-1:0] cfg_wdata
);

  state_t state, state_next;
  logic [5:0] cnt, cnt_next;
  logic m_valid_r, m_valid_next;
  logic [DEN_W-1:0] max_den;

  logic neg, neg_next;
  logic exact, exact_next;
  logic [VALUE_W-1:0] nc, nc_next, np, np_next;
  logic [DEN_W:0] dc, dc_next, dp, dp_next;
  logic [VALUE_W-1:0] b, b_next;
  logic [VALUE_W:0] r, r_next;
  logic [VALUE_W-1:0] q, q_next;
  logic [VALUE_W-1:0] mn, mn_next, md, md_next;
  logic [VALUE_W-1:0] acc_n, acc_n_next, acc_d, acc_d_next;
  logic [OUT_W-1:0] out_data, out_data_next;

  logic [VALUE_W:0] sh, sub;
  logic [DEN_W-1:0] lim;
  logic [VALUE_W+30:0] term_bound;
  logic [VALUE_W-1:0] mag, num_out;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = m_valid_r;
  assign m_tdata  = out_data;

  assign lim        = (max_den == '0) ? DEN_W'(1) : max_den;
  assign sh         = {r[VALUE_W-1:0], q[VALUE_W-1]};
  assign sub        = sh - {1'b0, b};
  assign term_bound = {r[VALUE_W-1:0], 31'b0} - {31'b0, r[VALUE_W-1:0]};
  assign mag        = s_tdata[IN_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
  assign num_out    = neg ? (VALUE_W'(0) - nc) : nc;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    m_valid_next  = m_valid_r;
    neg_next      = neg;
    exact_next    = exact;
    nc_next       = nc;
    np_next       = np;
    dc_next       = dc;
    dp_next       = dp;
    b_next        = b;
    r_next        = r;
    q_next        = q;
    mn_next       = mn;
    md_next       = md;
    acc_n_next    = acc_n;
    acc_d_next    = acc_d;
    out_data_next = out_data;

    if (m_valid_r && m_tready) begin
      m_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          neg_next   = s_tdata[IN_W-1];
          exact_next = 1'b0;
          nc_next    = VALUE_W'(1);
          np_next    = '0;
          dc_next    = '0;
          dp_next    = (DEN_W+1)'(1);
          b_next     = VALUE_W'(1) << FRAC_BITS;
          r_next     = '0;
          q_next     = mag;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sub[VALUE_W]) begin
          r_next = sub;
          q_next = {q[VALUE_W-2:0], 1'b1};
        end else begin
          r_next = sh;
          q_next = {q[VALUE_W-2:0], 1'b0};
        end
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) begin
          mn_next    = nc;
          md_next    = VALUE_W'(dc);
          acc_n_next = np;
          acc_d_next = VALUE_W'(dp);
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (q == '0) begin
          state_next = ST_CHECK;
        end else begin
          if (q[0]) begin
            acc_n_next = acc_n + mn;
            acc_d_next = acc_d + md;
          end
          mn_next = {mn[VALUE_W-2:0], 1'b0};
          md_next = {md[VALUE_W-2:0], 1'b0};
          q_next  = {1'b0, q[VALUE_W-1:1]};
        end
      end
      ST_CHECK: begin
        if (acc_d > VALUE_W'(lim)) begin
          state_next = ST_DONE;
        end else begin
          np_next = nc;
          nc_next = acc_n;
          dp_next = dc;
          dc_next = acc_d[DEN_W:0];
          if (r[VALUE_W-1:0] == '0) begin
            exact_next = 1'b1;
            state_next = ST_DONE;
          end else begin
            state_next = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        if ({31'b0, b} > term_bound) begin
          state_next = ST_DONE;
        end else begin
          q_next     = b;
          b_next     = r[VALUE_W-1:0];
          r_next     = '0;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DONE: begin
        if (!m_valid_r || m_tready) begin
          m_valid_next  = 1'b1;
          out_data_next = {7'b0, exact, dc[DEN_W-1:0], num_out};
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      m_valid_r <= 1'b0;
      max_den   <= MAX_DEN_RESET;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      m_valid_r <= m_valid_next;
      if (cfg_wen) begin
        max_den <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    neg      <= neg_next;
    exact    <= exact_next;
    nc       <= nc_next;
    np       <= np_next;
    dc       <= dc_next;
    dp       <= dp_next;
    b        <= b_next;
    r        <= r_next;
    q        <= q_next;
    mn       <= mn_next;
    md       <= md_next;
    acc_n    <= acc_n_next;
    acc_d    <= acc_d_next;
    out_data <= out_data_next;
  end

  // An accepted request always starts a fresh division.
  a_start_div: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_DIV && cnt == 6'd0))
    else $error("request accepted without starting the divider");

  // The divisor is never zero while dividing.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (b != '0))
    else $error("division by zero in the shared divider");

  // A delivered result never carries a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[95:64] != '0))
    else $error("result with zero denominator");

  // The divider runs exactly 64 steps before the multiplier starts.
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && $past(state) == ST_DIV) |-> ($past(cnt) == 6'd63))
    else $error("divider left early");

endmodule
